FILE: hdl/sro_pkg.sv
`timescale 1ns / 1ps
// Shared types and widths for the sequence reorder buffer.
package sro_pkg;

    localparam int ID_W   = 32;
    localparam int SLOT_W = 4;

    typedef logic [ID_W-1:0]   seq_id_t;
    typedef logic [SLOT_W-1:0] slot_id_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

endpackage

FILE: hdl/sro_cell.sv
`timescale 1ns / 1ps
// One entry of the sorted pending chain: keep, shift right on insert, shift left on pop.
module sro_cell
    import sro_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       valid,
    input  seq_id_t    new_id,
    input  seq_id_t    left_id,
    input  slot_id_t   left_slot,
    input  seq_id_t    right_id,
    input  slot_id_t   right_slot,
    output seq_id_t    id,
    output slot_id_t   slot,
    output logic       le
);

    seq_id_t  id_reg;
    seq_id_t  id_next;
    slot_id_t slot_reg;
    slot_id_t slot_next;

    // entry belongs before the newcomer (equal ids stay ahead)
    assign le = valid && (id_reg <= new_id);

    always_comb
    begin
        id_next   = id_reg;
        slot_next = slot_reg;
        if (ctrl.pop)
        begin
            id_next   = right_id;
            slot_next = right_slot;
        end
        else if (ctrl.insert && !le)
        begin
            // left neighbor is either the newcomer or an entry moving right
            id_next   = left_id;
            slot_next = left_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        slot_reg <= slot_next;
    end

    assign id   = id_reg;
    assign slot = slot_reg;

endmodule

FILE: hdl/sro_chain.sv
`timescale 1ns / 1ps
// Row of pending cells kept sorted by sequence id, with its fill count.
module sro_chain
    import sro_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int CNT_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  seq_id_t          new_id,
    input  slot_id_t         new_slot,
    output seq_id_t          head_id,
    output slot_id_t         head_slot,
    output seq_id_t          second_id,
    output logic [CNT_W-1:0] count,
    output logic             full
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    seq_id_t  id_w   [SLOTS];
    slot_id_t slot_w [SLOTS];
    logic     le_w   [SLOTS];

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        seq_id_t  l_id;
        slot_id_t l_slot;
        logic     l_le;
        seq_id_t  r_id;
        slot_id_t r_slot;
        seq_id_t  src_id;
        slot_id_t src_slot;

        if (i == 0)
        begin : g_first
            assign l_id   = new_id;
            assign l_slot = new_slot;
            assign l_le   = 1'b0;
        end
        else
        begin : g_mid
            assign l_id   = id_w[i-1];
            assign l_slot = slot_w[i-1];
            assign l_le   = le_w[i-1];
        end

        if (i == SLOTS - 1)
        begin : g_last
            assign r_id   = id_w[i];
            assign r_slot = slot_w[i];
        end
        else
        begin : g_inner
            assign r_id   = id_w[i+1];
            assign r_slot = slot_w[i+1];
        end

        // take the newcomer only where the left neighbor stays put
        assign src_id   = l_le ? new_id : l_id;
        assign src_slot = l_le ? new_slot : l_slot;

        sro_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid      (CNT_W'(i) < count_reg),
            .new_id     (new_id),
            .left_id    (src_id),
            .left_slot  (src_slot),
            .right_id   (r_id),
            .right_slot (r_slot),
            .id         (id_w[i]),
            .slot       (slot_w[i]),
            .le         (le_w[i])
        );
    end

    if (SLOTS > 1)
    begin : g_second
        assign second_id = id_w[1];
    end
    else
    begin : g_no_second
        assign second_id = id_w[0];
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head_id   = id_w[0];
    assign head_slot = slot_w[0];
    assign count     = count_reg;
    assign full      = (count_reg == CNT_W'(SLOTS));

endmodule

FILE: hdl/sequence_reorder_buffer.sv
`timescale 1ns / 1ps
// Sequence reorder buffer: releases filled slots in sequence order.
// Out-of-order request: inserted into the sorted cell chain, or dropped when the chain is full.
// In-order request: held in the hold registers, then loaded into the output register once
//   it is free; then one held entry drains per cycle from the chain head while it stays free.
// The output register lets the next request be taken while the last result waits.
// Reset clears the delivered counter, the chain fill count and the control state.
module sequence_reorder_buffer
    import sro_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  slot_id_t slot_index,
    input  seq_id_t  sequence_number,
    output logic     result_valid,
    input  logic     result_ready,
    output slot_id_t out_slot,
    output seq_id_t  out_sequence,
    output logic     last
);

    localparam int CNT_W = $clog2(SLOTS + 1);

    state_t           state_reg, state_next;
    seq_id_t          delivered_reg, delivered_next;
    logic [CNT_W-1:0] n_reg, n_next;
    seq_id_t          hold_id_reg, hold_id_next;
    slot_id_t         hold_slot_reg, hold_slot_next;
    logic             result_valid_reg, result_valid_next;
    slot_id_t         out_slot_reg, out_slot_next;
    seq_id_t          out_sequence_reg, out_sequence_next;
    logic             last_reg, last_next;

    cell_ctrl_t       ctrl;
    seq_id_t          head_id;
    slot_id_t         head_slot;
    seq_id_t          second_id;
    logic [CNT_W-1:0] count;
    logic             full;
    logic             out_free;
    logic             load;
    logic             more;

    sro_chain #(
        .SLOTS (SLOTS),
        .CNT_W (CNT_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .new_id    (sequence_number),
        .new_slot  (slot_index),
        .head_id   (head_id),
        .head_slot (head_slot),
        .second_id (second_id),
        .count     (count),
        .full      (full)
    );

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next        = state_reg;
        delivered_next    = delivered_reg;
        n_next            = n_reg;
        hold_id_next      = hold_id_reg;
        hold_slot_next    = hold_slot_reg;
        out_slot_next     = out_slot_reg;
        out_sequence_next = out_sequence_reg;
        last_next         = last_reg;
        ctrl              = '0;
        item_ready        = 1'b0;
        load              = 1'b0;
        more              = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (sequence_number == delivered_reg + 1'b1)
                    begin
                        hold_id_next   = sequence_number;
                        hold_slot_next = slot_index;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        // drop when full
                        ctrl.insert = !full;
                    end
                end
            end
            ST_EMIT:
            begin
                more = (count != '0) && (head_id == hold_id_reg + 1'b1) && (SLOTS > 1);
                if (out_free)
                begin
                    load              = 1'b1;
                    out_slot_next     = hold_slot_reg;
                    out_sequence_next = hold_id_reg;
                    last_next         = !more;
                    delivered_next    = hold_id_reg;
                    n_next            = CNT_W'(1);
                    state_next        = more ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                more = (count > CNT_W'(1)) && (second_id == head_id + 1'b1)
                    && (CNT_W'(n_reg + 1'b1) < CNT_W'(SLOTS));
                if (out_free)
                begin
                    load              = 1'b1;
                    ctrl.pop          = 1'b1;
                    out_slot_next     = head_slot;
                    out_sequence_next = head_id;
                    last_next         = !more;
                    delivered_next    = head_id;
                    n_next            = CNT_W'(n_reg + 1'b1);
                    state_next        = more ? ST_DRAIN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            delivered_reg    <= '0;
            n_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            delivered_reg    <= delivered_next;
            n_reg            <= n_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_id_reg      <= hold_id_next;
        hold_slot_reg    <= hold_slot_next;
        out_slot_reg     <= out_slot_next;
        out_sequence_reg <= out_sequence_next;
        last_reg         <= last_next;
    end

    assign result_valid = result_valid_reg;
    assign out_slot     = out_slot_reg;
    assign out_sequence = out_sequence_reg;
    assign last         = last_reg;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> (count != '0))
        else $error("pop from empty pending chain");

    a_no_insert_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.insert && ctrl.pop))
        else $error("insert and pop in the same cycle");

    a_drain_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && load) |-> (head_id == delivered_reg + 1'b1))
        else $error("drained entry is not next in order");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(SLOTS))
        else $error("pending count above capacity");

endmodule
